@@ hw/rtl/ert_pkg.sv @@
package ert_pkg;

  // table geometry
  localparam int WATCH_SLOTS = 16;
  localparam int KEY_BITS    = 10;
  localparam int SLOT_BITS   = $clog2(WATCH_SLOTS);
  localparam int MAX_RES     = 16;
  localparam int CNT_BITS    = $clog2(MAX_RES + 1);
  localparam int LIST_BITS   = $clog2(MAX_RES);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [LIST_BITS-1:0] list_idx_t;

  // command codes
  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_MOD  = 3'd1;
  localparam logic [2:0] CMD_DEL  = 3'd2;
  localparam logic [2:0] CMD_STAT = 3'd3;
  localparam logic [2:0] CMD_COL  = 3'd4;

  // result codes
  localparam logic [2:0] RC_OK     = 3'd0;
  localparam logic [2:0] RC_CLOSED = 3'd1;
  localparam logic [2:0] RC_EXISTS = 3'd2;
  localparam logic [2:0] RC_NOENT  = 3'd3;
  localparam logic [2:0] RC_BADCMD = 3'd4;
  localparam logic [2:0] RC_FULL   = 3'd5;

  // interest bit positions
  localparam int IN_RD = 0;
  localparam int IN_WR = 1;
  localparam int IN_ET = 2;
  localparam int IN_OS = 3;

  // status bit positions
  localparam int ST_ACT = 0;
  localparam int ST_RD  = 1;
  localparam int ST_WR  = 2;
  localparam int ST_CL  = 3;
  localparam int ST_RCH = 4;
  localparam int ST_WCH = 5;
  localparam int ST_ETR = 6;
  localparam int ST_OSR = 7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
    logic walk_clr;
    logic walk_step;
    logic walk_upd;
    logic emit_init;
    logic emit_res;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic is_collect;
    logic best_found;
    logic more;
    logic has_events;
    logic emit_last;
  } ctrl_st_t;

  // readiness rule for one watch
  function automatic logic is_ready(input logic v, input logic [3:0] n,
                                    input logic [7:0] s);
    logic hr;
    logic hw;
    logic r;
    hr = s[ST_RD] & n[IN_RD];
    hw = s[ST_WR] & n[IN_WR];
    if (n[IN_ET]) begin
      r = (hr & (s[ST_RCH] | ~s[ST_ETR])) | (hw & (s[ST_WCH] | ~s[ST_ETR]));
    end else begin
      r = hr | hw;
    end
    if (n[IN_OS] & s[ST_OSR]) r = 1'b0;
    if (!v || s[ST_CL] || !s[ST_ACT]) r = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/event_readiness_table_unit.sv @@
// Non-collect commands: the result strobe follows a lookup scan over all WATCH_SLOTS
// slots, one update step (EXEC) and one result step (EMIT).
// Collect: one walk over all WATCH_SLOTS slots per marked watch taken in key order
// (reported only if still ready), plus a final walk unless the limit is reached,
// then one result per cycle. The slot-by-slot walk dominates; one item at a time.
// Synchronous reset empties the table; results cannot be stalled by the receiver.
module event_readiness_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [9:0]  fd,
  input  logic        want_in,
  input  logic        want_out,
  input  logic        edge_mode,
  input  logic        one_shot,
  input  logic [63:0] user_data,
  input  logic        status_active,
  input  logic        status_readable,
  input  logic        status_writable,
  input  logic        status_closed,
  input  logic [4:0]  max_events,
  output logic        done,
  output logic [2:0]  result_code,
  output logic        ev_valid,
  output logic [63:0] ev_data,
  output logic        ev_in,
  output logic        ev_out,
  output logic        last,
  output logic        any_ready
);

  ert_pkg::ctrl_cmd_t c;
  ert_pkg::ctrl_st_t  st;

  ert_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .c     (c)
  );

  ert_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .c               (c),
    .st              (st),
    .cmd             (cmd),
    .fd              (fd),
    .want_in         (want_in),
    .want_out        (want_out),
    .edge_mode       (edge_mode),
    .one_shot        (one_shot),
    .user_data       (user_data),
    .status_active   (status_active),
    .status_readable (status_readable),
    .status_writable (status_writable),
    .status_closed   (status_closed),
    .max_events      (max_events),
    .done            (done),
    .result_code     (result_code),
    .ev_valid        (ev_valid),
    .ev_data         (ev_data),
    .ev_in           (ev_in),
    .ev_out          (ev_out),
    .last            (last),
    .any_ready       (any_ready)
  );

endmodule

@@ hw/rtl/ert_ctrl.sv @@
module ert_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ert_pkg::ctrl_st_t  st,
  output ert_pkg::ctrl_cmd_t c
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WCHK = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_WEND = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    c = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          c.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.is_collect) begin
          state_next = S_WCHK;
        end else begin
          c.scan_step = 1'b1;
          if (st.scan_last) state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        c.exec = 1'b1;
        c.emit_init = 1'b0;
        state_next = S_EMIT;
      end
      S_WCHK: begin
        if (st.more) begin
          c.walk_clr = 1'b1;
          state_next = S_WALK;
        end else begin
          c.emit_init = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_WALK: begin
        c.walk_step = 1'b1;
        if (st.scan_last) state_next = S_WEND;
      end
      S_WEND: begin
        if (st.best_found) begin
          c.walk_upd = 1'b1;
          state_next = S_WCHK;
        end else begin
          c.emit_init = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        c.emit_res = 1'b1;
        if (st.emit_last || !st.has_events) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ hw/rtl/ert_dp.sv @@
module ert_dp (
  input  logic               clk,
  input  logic               rst,
  input  ert_pkg::ctrl_cmd_t c,
  output ert_pkg::ctrl_st_t  st,
  input  logic [2:0]         cmd,
  input  logic [9:0]         fd,
  input  logic               want_in,
  input  logic               want_out,
  input  logic               edge_mode,
  input  logic               one_shot,
  input  logic [63:0]        user_data,
  input  logic               status_active,
  input  logic               status_readable,
  input  logic               status_writable,
  input  logic               status_closed,
  input  logic [4:0]         max_events,
  output logic               done,
  output logic [2:0]         result_code,
  output logic               ev_valid,
  output logic [63:0]        ev_data,
  output logic               ev_in,
  output logic               ev_out,
  output logic               last,
  output logic               any_ready
);

  localparam int S = ert_pkg::WATCH_SLOTS;

  // watch table
  logic [S-1:0]        valid;
  logic [S-1:0]        mark;
  ert_pkg::key_t       tkey [S];
  logic [63:0]         tpl  [S];
  logic [3:0]          tint [S];
  logic [7:0]          tst  [S];

  // latched command
  logic [2:0]          cmd_q;
  ert_pkg::key_t       key_q;
  logic [3:0]          int_q;
  logic [63:0]         data_q;
  logic [3:0]          stat_q;
  ert_pkg::cnt_t       limit_q;
  logic [2:0]          code_q;

  // scan and walk trackers
  ert_pkg::slot_t      idx;
  logic                match_found;
  ert_pkg::slot_t      match_slot;
  logic                free_found;
  ert_pkg::slot_t      free_slot;
  logic                best_found;
  ert_pkg::slot_t      best;
  ert_pkg::key_t       best_key;
  logic                started;
  ert_pkg::key_t       prev;
  ert_pkg::cnt_t       count;
  ert_pkg::slot_t      list [ert_pkg::MAX_RES];
  ert_pkg::list_idx_t  k;

  // single read port
  ert_pkg::slot_t      rd_a;
  ert_pkg::key_t       rd_key;
  logic [63:0]         rd_pl;
  logic [3:0]          rd_int;
  logic [7:0]          rd_st;
  logic                rd_v;

  // write port
  logic                tab_we;
  logic                vm_we;
  ert_pkg::slot_t      wa;
  logic [63:0]         w_pl;
  logic [3:0]          w_int;
  logic [7:0]          w_st;
  ert_pkg::key_t       w_key;
  logic                w_valid;
  logic                w_mark;
  logic [2:0]          code_next;

  logic [7:0]          sbits;
  logic [7:0]          add_st;
  logic [7:0]          mod_st;
  logic [7:0]          chg_st;
  logic [7:0]          col_st;
  logic                ready_now;
  logic                cand;
  logic                ev_have;

  always_comb begin
    if (c.walk_upd) rd_a = best;
    else if (c.exec) rd_a = match_slot;
    else if (c.emit_res) rd_a = list[k];
    else rd_a = idx;
  end

  assign rd_key = tkey[rd_a];
  assign rd_pl  = tpl[rd_a];
  assign rd_int = tint[rd_a];
  assign rd_st  = tst[rd_a];
  assign rd_v   = valid[rd_a];

  // candidate status words
  always_comb begin
    sbits = {4'b0000, stat_q};
    add_st = sbits;
    add_st[ert_pkg::ST_RCH] = sbits[ert_pkg::ST_RD];
    add_st[ert_pkg::ST_WCH] = sbits[ert_pkg::ST_WR];
    mod_st = rd_st;
    mod_st[ert_pkg::ST_ETR] = 1'b0;
    mod_st[ert_pkg::ST_OSR] = 1'b0;
    chg_st = (rd_st & 8'hF0) | sbits;
    if (rd_st[ert_pkg::ST_RD] != sbits[ert_pkg::ST_RD]) chg_st[ert_pkg::ST_RCH] = 1'b1;
    if (rd_st[ert_pkg::ST_WR] != sbits[ert_pkg::ST_WR]) chg_st[ert_pkg::ST_WCH] = 1'b1;
    col_st = rd_st;
    col_st[ert_pkg::ST_RCH] = 1'b0;
    col_st[ert_pkg::ST_WCH] = 1'b0;
    if (rd_int[ert_pkg::IN_ET]) col_st[ert_pkg::ST_ETR] = 1'b1;
    if (rd_int[ert_pkg::IN_OS]) col_st[ert_pkg::ST_OSR] = 1'b1;
    ready_now = ert_pkg::is_ready(rd_v, rd_int, rd_st);
  end

  // command execution and walk update
  always_comb begin
    tab_we = 1'b0;
    vm_we = 1'b0;
    wa = match_slot;
    w_key = rd_key;
    w_pl = rd_pl;
    w_int = rd_int;
    w_st = rd_st;
    w_valid = 1'b1;
    w_mark = 1'b0;
    code_next = code_q;
    if (c.exec) begin
      case (cmd_q)
        ert_pkg::CMD_ADD: begin
          if (stat_q[ert_pkg::ST_CL]) begin
            code_next = ert_pkg::RC_CLOSED;
          end else if (match_found) begin
            code_next = ert_pkg::RC_EXISTS;
          end else if (!free_found) begin
            code_next = ert_pkg::RC_FULL;
          end else begin
            tab_we = 1'b1;
            vm_we = 1'b1;
            wa = free_slot;
            w_key = key_q;
            w_pl = data_q;
            w_int = int_q;
            w_st = add_st;
            w_mark = ert_pkg::is_ready(1'b1, int_q, add_st);
            code_next = ert_pkg::RC_OK;
          end
        end
        ert_pkg::CMD_MOD: begin
          if (!match_found) begin
            code_next = ert_pkg::RC_NOENT;
          end else begin
            tab_we = 1'b1;
            vm_we = 1'b1;
            w_pl = data_q;
            w_int = int_q;
            w_st = mod_st;
            w_valid = ~mod_st[ert_pkg::ST_CL];
            w_mark = ert_pkg::is_ready(1'b1, int_q, mod_st);
            code_next = ert_pkg::RC_OK;
          end
        end
        ert_pkg::CMD_DEL: begin
          if (!match_found) begin
            code_next = ert_pkg::RC_NOENT;
          end else begin
            vm_we = 1'b1;
            w_valid = 1'b0;
            code_next = ert_pkg::RC_OK;
          end
        end
        ert_pkg::CMD_STAT: begin
          if (!match_found) begin
            code_next = ert_pkg::RC_NOENT;
          end else begin
            tab_we = 1'b1;
            vm_we = 1'b1;
            w_st = chg_st;
            w_valid = ~chg_st[ert_pkg::ST_CL];
            w_mark = ert_pkg::is_ready(1'b1, rd_int, chg_st);
            code_next = ert_pkg::RC_OK;
          end
        end
        default: code_next = ert_pkg::RC_BADCMD;
      endcase
    end else if (c.walk_upd) begin
      wa = best;
      vm_we = 1'b1;
      if (ready_now) begin
        tab_we = 1'b1;
        w_st = col_st;
        w_mark = ert_pkg::is_ready(1'b1, rd_int, col_st);
      end
    end
  end

  // table payload, no reset
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tkey[wa] <= w_key;
      tpl[wa]  <= w_pl;
      tint[wa] <= w_int;
      tst[wa]  <= w_st;
    end
  end

  // valid and ready marks
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      mark <= '0;
    end else if (vm_we) begin
      valid[wa] <= w_valid;
      mark[wa] <= w_mark & w_valid;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (c.load) begin
      cmd_q <= cmd;
      key_q <= ert_pkg::key_t'(fd);
      int_q <= {one_shot, edge_mode, want_out, want_in};
      data_q <= user_data;
      stat_q <= {status_closed, status_writable, status_readable, status_active};
      limit_q <= (max_events > 5'(ert_pkg::MAX_RES)) ? ert_pkg::cnt_t'(ert_pkg::MAX_RES)
                                                     : ert_pkg::cnt_t'(max_events);
    end
  end

  assign cand = valid[idx] & mark[idx] & (~started | (rd_key > prev));

  // lookup scan, walk trackers, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      match_found <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      started <= 1'b0;
      count <= '0;
      k <= '0;
      code_q <= ert_pkg::RC_OK;
    end else begin
      if (c.load) begin
        idx <= '0;
        match_found <= 1'b0;
        free_found <= 1'b0;
        started <= 1'b0;
        count <= '0;
        code_q <= ert_pkg::RC_OK;
      end
      if (c.scan_step) begin
        idx <= idx + 1'b1;
        if (valid[idx] && rd_key == key_q) begin
          match_found <= 1'b1;
          match_slot <= idx;
        end
        if (!valid[idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= idx;
        end
      end
      if (c.exec) code_q <= code_next;
      if (c.walk_clr) begin
        idx <= '0;
        best_found <= 1'b0;
      end
      if (c.walk_step) begin
        idx <= idx + 1'b1;
        if (cand && (!best_found || rd_key < best_key)) begin
          best_found <= 1'b1;
          best <= idx;
          best_key <= rd_key;
        end
      end
      if (c.walk_upd) begin
        started <= 1'b1;
        prev <= best_key;
        if (ready_now) count <= count + 1'b1;
      end
      if (c.emit_init) k <= '0;
      if (c.emit_res) k <= k + 1'b1;
    end
  end

  // reported slot list
  always_ff @(posedge clk) begin
    if (c.walk_upd && ready_now) list[count[ert_pkg::LIST_BITS-1:0]] <= best;
  end

  assign ev_have = (cmd_q == ert_pkg::CMD_COL) && (count != '0);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c.emit_res;
    end
    if (c.emit_res) begin
      any_ready <= |(valid & mark);
      if (ev_have) begin
        result_code <= ert_pkg::RC_OK;
        ev_valid <= 1'b1;
        ev_data <= rd_pl;
        ev_in <= rd_st[ert_pkg::ST_RD] & rd_int[ert_pkg::IN_RD];
        ev_out <= rd_st[ert_pkg::ST_WR] & rd_int[ert_pkg::IN_WR];
        last <= st.emit_last;
      end else begin
        result_code <= code_q;
        ev_valid <= 1'b0;
        ev_data <= '0;
        ev_in <= 1'b0;
        ev_out <= 1'b0;
        last <= 1'b1;
      end
    end
  end

  // status to controller
  assign st.scan_last  = (idx == ert_pkg::slot_t'(S - 1));
  assign st.is_collect = (cmd_q == ert_pkg::CMD_COL);
  assign st.best_found = best_found;
  assign st.more       = (count < limit_q);
  assign st.has_events = ev_have;
  assign st.emit_last  = ((ert_pkg::cnt_t'(k) + ert_pkg::cnt_t'(1)) == count);

  a_ev_ok: assert property (@(posedge clk) disable iff (rst)
    done && ev_valid |-> result_code == ert_pkg::RC_OK)
    else $error("event result with nonzero code");

  a_mark_valid: assert property (@(posedge clk) disable iff (rst)
    (mark & ~valid) == '0)
    else $error("ready mark on an empty slot");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({c.load, c.scan_step, c.exec, c.walk_clr, c.walk_step, c.walk_upd,
              c.emit_init, c.emit_res}))
    else $error("overlapping datapath commands");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    st.is_collect && !c.load |-> count <= limit_q)
    else $error("collect reported past its limit");

endmodule

@@ sim/event_readiness_table_unit_tb.sv @@
`timescale 1ns / 100ps

module event_readiness_table_unit_tb;
  import ert_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  // one watch entry of the model table
  typedef struct {
    bit          used;
    bit [9:0]    key;
    bit [63:0]   data;
    bit [3:0]    interest;
    bit [7:0]    status;
    bit          marked;
  } watch_t;

  // one command item
  typedef struct {
    bit [2:0]  cmd;
    bit [9:0]  fd;
    bit        win;
    bit        wout;
    bit        edge_m;
    bit        oneshot;
    bit [63:0] udata;
    bit        s_act;
    bit        s_rd;
    bit        s_wr;
    bit        s_cl;
    bit [4:0]  max_ev;
  } item_t;

  // one result
  typedef struct {
    bit [2:0]  code;
    bit        valid;
    bit [63:0] data;
    bit        ein;
    bit        eout;
    bit        lst;
    bit        anyr;
  } event_res_t;

  // directed row: item plus optional typed-in result code
  typedef struct {
    item_t    it;
    bit       has_code;
    bit [2:0] code;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  cmd;
  logic [9:0]  fd;
  logic        want_in;
  logic        want_out;
  logic        edge_mode;
  logic        one_shot;
  logic [63:0] user_data;
  logic        status_active;
  logic        status_readable;
  logic        status_writable;
  logic        status_closed;
  logic [4:0]  max_events;
  logic        done;
  logic [2:0]  result_code;
  logic        ev_valid;
  logic [63:0] ev_data;
  logic        ev_in;
  logic        ev_out;
  logic        last;
  logic        any_ready;

  watch_t     watches [WATCH_SLOTS];
  event_res_t pending_results [$];
  int         fail_count;
  int         cycle_count;
  bit [9:0]   key_pool [8];

  event_readiness_table_unit u_dut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watch readiness under level, edge and one-shot rules
  function automatic bit watch_ready(watch_t w);
    bit hr;
    bit hw;
    bit r;
    hr = w.status[ST_RD] & w.interest[IN_RD];
    hw = w.status[ST_WR] & w.interest[IN_WR];
    if (!w.used || w.status[ST_CL] || !w.status[ST_ACT]) return 1'b0;
    if (w.interest[IN_ET])
      r = (hr & (w.status[ST_RCH] | ~w.status[ST_ETR])) |
          (hw & (w.status[ST_WCH] | ~w.status[ST_ETR]));
    else
      r = hr | hw;
    if (r && w.interest[IN_OS] && w.status[ST_OSR]) r = 1'b0;
    return r;
  endfunction

  function automatic void rearm(int i);
    watches[i].marked = watch_ready(watches[i]);
    if (watches[i].status[ST_CL]) begin
      watches[i].used   = 1'b0;
      watches[i].marked = 1'b0;
    end
  endfunction

  // apply one item to the model table and queue its results
  function automatic void predict_table(item_t it);
    int slot;
    int free_slot;
    int best;
    int n_ev;
    int limit;
    bit started;
    bit [9:0] prev;
    bit [7:0] s;
    bit [7:0] old;
    bit [2:0] code;
    bit anyr;
    event_res_t batch [$];
    event_res_t r;
    slot = -1;
    free_slot = -1;
    code = RC_OK;
    n_ev = 0;
    started = 1'b0;
    prev = '0;
    for (int i = 0; i < WATCH_SLOTS; i++)
      if (watches[i].used && watches[i].key == it.fd && slot < 0) slot = i;
    s = {4'b0, it.s_cl, it.s_wr, it.s_rd, it.s_act};
    case (it.cmd)
      CMD_ADD: begin
        for (int i = WATCH_SLOTS - 1; i >= 0; i--)
          if (!watches[i].used) free_slot = i;
        if (s[ST_CL]) code = RC_CLOSED;
        else if (slot >= 0) code = RC_EXISTS;
        else if (free_slot < 0) code = RC_FULL;
        else begin
          s[ST_RCH] = s[ST_RD];
          s[ST_WCH] = s[ST_WR];
          watches[free_slot].used     = 1'b1;
          watches[free_slot].key      = it.fd;
          watches[free_slot].data     = it.udata;
          watches[free_slot].interest = {it.oneshot, it.edge_m, it.wout, it.win};
          watches[free_slot].status   = s;
          rearm(free_slot);
        end
      end
      CMD_MOD: begin
        if (slot < 0) code = RC_NOENT;
        else begin
          watches[slot].interest = {it.oneshot, it.edge_m, it.wout, it.win};
          watches[slot].data = it.udata;
          watches[slot].status[ST_ETR] = 1'b0;
          watches[slot].status[ST_OSR] = 1'b0;
          rearm(slot);
        end
      end
      CMD_DEL: begin
        if (slot < 0) code = RC_NOENT;
        else begin
          watches[slot].used   = 1'b0;
          watches[slot].marked = 1'b0;
        end
      end
      CMD_STAT: begin
        if (slot < 0) code = RC_NOENT;
        else begin
          old = watches[slot].status;
          s[7:4] = old[7:4];
          if (old[ST_RD] != s[ST_RD]) s[ST_RCH] = 1'b1;
          if (old[ST_WR] != s[ST_WR]) s[ST_WCH] = 1'b1;
          watches[slot].status = s;
          rearm(slot);
        end
      end
      CMD_COL: begin
        limit = (it.max_ev > MAX_RES) ? MAX_RES : it.max_ev;
        while (n_ev < limit) begin
          best = -1;
          for (int i = 0; i < WATCH_SLOTS; i++) begin
            if (!watches[i].used || !watches[i].marked) continue;
            if (started && watches[i].key <= prev) continue;
            if (best < 0 || watches[i].key < watches[best].key) best = i;
          end
          if (best < 0) break;
          started = 1'b1;
          prev = watches[best].key;
          if (!watch_ready(watches[best])) begin
            watches[best].marked = 1'b0;
            continue;
          end
          r = '{RC_OK, 1'b1, watches[best].data,
                watches[best].status[ST_RD] & watches[best].interest[IN_RD],
                watches[best].status[ST_WR] & watches[best].interest[IN_WR],
                1'b0, 1'b0};
          batch.push_back(r);
          n_ev++;
          watches[best].status[ST_RCH] = 1'b0;
          watches[best].status[ST_WCH] = 1'b0;
          if (watches[best].interest[IN_ET]) watches[best].status[ST_ETR] = 1'b1;
          if (watches[best].interest[IN_OS]) watches[best].status[ST_OSR] = 1'b1;
          if (!watch_ready(watches[best])) watches[best].marked = 1'b0;
        end
      end
      default: code = RC_BADCMD;
    endcase
    if (batch.size() == 0) batch.push_back('{code, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0});
    anyr = 1'b0;
    for (int i = 0; i < WATCH_SLOTS; i++)
      if (watches[i].used && watches[i].marked) anyr = 1'b1;
    foreach (batch[k]) begin
      batch[k].anyr = anyr;
      batch[k].lst  = (k == batch.size() - 1);
      pending_results.push_back(batch[k]);
    end
  endfunction

  // drive one item and wait for its accept edge
  task automatic issue_item(item_t it);
    while (busy !== 1'b0) @(negedge clk);
    cmd <= it.cmd;
    fd <= it.fd;
    want_in <= it.win;
    want_out <= it.wout;
    edge_mode <= it.edge_m;
    one_shot <= it.oneshot;
    user_data <= it.udata;
    status_active <= it.s_act;
    status_readable <= it.s_rd;
    status_writable <= it.s_wr;
    status_closed <= it.s_cl;
    max_events <= it.max_ev;
    start <= 1'b1;
    @(posedge clk);
    predict_table(it);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic item_t make_item(bit [2:0] c, bit [9:0] f, bit [3:0] n,
                                      bit [3:0] st, bit [63:0] d, bit [4:0] m);
    item_t it;
    it.cmd = c;
    it.fd = f;
    {it.oneshot, it.edge_m, it.wout, it.win} = n;
    {it.s_cl, it.s_wr, it.s_rd, it.s_act} = st;
    it.udata = d;
    it.max_ev = m;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = make_item(CMD_ADD, key_pool[$urandom_range(0, 7)], 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), {$urandom, $urandom},
                   5'($urandom_range(0, 31)));
    if ($urandom_range(0, 9) == 0) it.fd = 10'($urandom_range(0, 1023));
    if (pick < 25) begin
      it.cmd = CMD_ADD;
      it.s_cl = ($urandom_range(0, 7) == 0);
    end else if (pick < 38) it.cmd = CMD_MOD;
    else if (pick < 46) it.cmd = CMD_DEL;
    else if (pick < 72) begin
      it.cmd = CMD_STAT;
      it.s_cl = ($urandom_range(0, 9) == 0);
    end else if (pick < 96) it.cmd = CMD_COL;
    else it.cmd = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    event_res_t want;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result code=%0d data=%h", $time, result_code, ev_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_code !== want.code || ev_valid !== want.valid ||
              ev_data !== want.data || ev_in !== want.ein || ev_out !== want.eout ||
              last !== want.lst || any_ready !== want.anyr) begin
            $display("%0t: mismatch expected code=%0d v=%b d=%h in=%b out=%b last=%b any=%b",
                     $time, want.code, want.valid, want.data, want.ein, want.eout,
                     want.lst, want.anyr);
            $display("%0t:          actual code=%0d v=%b d=%h in=%b out=%b last=%b any=%b",
                     $time, result_code, ev_valid, ev_data, ev_in, ev_out, last, any_ready);
            fail_count++;
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t  rows [$];
    item_t it;
    fail_count = 0;
    cycle_count = 0;
    foreach (watches[i]) watches[i] = '{1'b0, '0, '0, '0, '0, 1'b0};
    key_pool = '{10'd0, 10'd1023, 10'd5, 10'd512, 10'd77, 10'd300, 10'd341, 10'd682};
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_ADD;
    fd = '0;
    want_in = 1'b0;
    want_out = 1'b0;
    edge_mode = 1'b0;
    one_shot = 1'b0;
    user_data = '0;
    status_active = 1'b0;
    status_readable = 1'b0;
    status_writable = 1'b0;
    status_closed = 1'b0;
    max_events = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: interest {os,et,wr,rd}, status {cl,wr,rd,act}
    rows.push_back('{make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd16), 1, RC_OK});
    rows.push_back('{make_item(CMD_MOD, 10'd1023, 4'h3, 4'h0, 64'd1, 5'd0), 1, RC_NOENT});
    rows.push_back('{make_item(CMD_DEL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd0), 1, RC_NOENT});
    rows.push_back('{make_item(CMD_STAT, 10'd9, 4'h0, 4'h3, 64'd0, 5'd0), 1, RC_NOENT});
    rows.push_back('{make_item(3'd7, 10'd0, 4'h0, 4'h0, 64'd0, 5'd0), 1, RC_BADCMD});
    rows.push_back('{make_item(3'd5, 10'd1, 4'h0, 4'h0, 64'd0, 5'd0), 1, RC_BADCMD});
    rows.push_back('{make_item(CMD_ADD, 10'd4, 4'h3, 4'hF, 64'd3, 5'd0), 1, RC_CLOSED});
    rows.push_back('{make_item(CMD_ADD, 10'd1023, 4'h3, 4'h7, '1, 5'd0), 1, RC_OK});
    rows.push_back('{make_item(CMD_ADD, 10'd1023, 4'h1, 4'h1, 64'd2, 5'd0), 1, RC_EXISTS});
    rows.push_back('{make_item(CMD_ADD, 10'd0, 4'h5, 4'h3, 64'hA5A5, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_ADD, 10'd20, 4'hA, 4'h5, 64'h55, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd31), 0, 0});
    rows.push_back('{make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd1), 0, 0});
    rows.push_back('{make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_STAT, 10'd0, 4'h0, 4'h1, 64'd0, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_STAT, 10'd0, 4'h0, 4'h3, 64'd0, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_MOD, 10'd20, 4'hF, 4'h0, 64'h77, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd16), 0, 0});
    rows.push_back('{make_item(CMD_STAT, 10'd1023, 4'h0, 4'h8, 64'd0, 5'd0), 0, 0});
    rows.push_back('{make_item(CMD_DEL, 10'd20, 4'h0, 4'h0, 64'd0, 5'd0), 1, RC_OK});
    foreach (rows[r]) begin
      issue_item(rows[r].it);
      // the newest queued result belongs to this row
      if (rows[r].has_code && pending_results[$].code != rows[r].code) begin
        $display("%0t: table row %0d expected code=%0d predicted=%0d", $time, r,
                 rows[r].code, pending_results[$].code);
        fail_count++;
      end
      random_gap();
    end

    // fill the table to force the full error, then collect all
    for (int i = 0; i < WATCH_SLOTS + 1; i++)
      issue_item(make_item(CMD_ADD, 10'(100 + i), 4'h3, 4'h7, {$urandom, $urandom}, 5'd0));
    issue_item(make_item(CMD_COL, 10'd0, 4'h0, 4'h0, 64'd0, 5'd16));
    for (int i = 0; i < WATCH_SLOTS + 1; i++)
      issue_item(make_item(CMD_DEL, 10'(100 + i), 4'h0, 4'h0, 64'd0, 5'd0));

    // random part, with one drain pause in the middle
    for (int n = 0; n < 265; n++) begin
      it = random_item();
      issue_item(it);
      random_gap();
      if (n == 130) while (pending_results.size() != 0) @(negedge clk);
    end

    while (pending_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ event_readiness_table_unit.f @@
hw/rtl/ert_pkg.sv
hw/rtl/ert_ctrl.sv
hw/rtl/ert_dp.sv
hw/rtl/event_readiness_table_unit.sv
sim/event_readiness_table_unit_tb.sv
